>>> design/ucbcs_pkg.sv
// ----------------------------------------------------------------------------
// ucbcs_pkg
// Shared types and constants for the UCB1 child selection block.
// ----------------------------------------------------------------------------
package ucbcs_pkg;

  localparam int MAX_CHILDREN_DEF = 64;

  localparam int VISITS_W  = 20;
  localparam int WINS_W    = 21;
  localparam int WEIGHT_W  = 16;
  localparam int INDEX_W   = 6;
  localparam int SCORE_W   = 24;
  localparam int LOG_W     = 21;   // Q5.16
  localparam int LN_W      = 20;   // Q4.16
  localparam int DIVD_W    = 36;   // dividend and quotient
  localparam int ROOT_W    = 18;
  localparam int EXPL_W    = 17;   // Q1.16 exploit term
  localparam int MANT_W    = 31;   // Q1.30 mantissa

  localparam int DIV_STEPS  = 36;
  localparam int SQRT_STEPS = 18;
  localparam int FRAC_BITS  = 16;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd5793;
  localparam logic [15:0]         LN2_Q16      = 16'd45426;
  localparam logic [SCORE_W-1:0]  SCORE_MAX    = 24'hFFFFFF;
  localparam logic [EXPL_W-1:0]   WR_ONE       = 17'd65536;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQUARE
  } log_phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR,
    ST_LOG,
    ST_LN,
    ST_RT_GO,
    ST_RT,
    ST_SQRT,
    ST_SCORE,
    ST_DONE,
    ST_EMIT
  } sel_state_t;

endpackage

>>> design/ucbcs_div.sv
// ----------------------------------------------------------------------------
// ucbcs_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ucbcs_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [ucbcs_pkg::DIVD_W-1:0]       dividend,
  input  logic [ucbcs_pkg::VISITS_W-1:0]     divisor,
  output logic                               done,
  output logic [ucbcs_pkg::DIVD_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(ucbcs_pkg::DIV_STEPS);

  logic [ucbcs_pkg::DIVD_W-1:0]   quo;
  logic [ucbcs_pkg::VISITS_W-1:0] rem;
  logic [ucbcs_pkg::VISITS_W-1:0] divr;
  logic [CNT_W-1:0]               cnt;
  logic                           busy;

  logic [ucbcs_pkg::VISITS_W:0]   trial;
  logic [ucbcs_pkg::VISITS_W:0]   diff;
  logic                           ge;

  always_comb begin
    trial = {rem, quo[ucbcs_pkg::DIVD_W-1]};
    diff  = trial - {1'b0, divr};
    ge    = trial >= {1'b0, divr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        divr <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[ucbcs_pkg::DIVD_W-2:0], ge};
        rem <= ge ? diff[ucbcs_pkg::VISITS_W-1:0] : trial[ucbcs_pkg::VISITS_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ucbcs_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

>>> design/ucbcs_log2.sv
// ----------------------------------------------------------------------------
// ucbcs_log2
// Base-2 log in Q5.16: serial normalise, then one mantissa square a cycle.
// ----------------------------------------------------------------------------
module ucbcs_log2 (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ucbcs_pkg::VISITS_W-1:0]  p,
  output logic                            done,
  output logic [ucbcs_pkg::LOG_W-1:0]     log_q
);

  localparam int EXP_W = ucbcs_pkg::LOG_W - ucbcs_pkg::FRAC_BITS;
  localparam int CNT_W = $clog2(ucbcs_pkg::FRAC_BITS);
  localparam int PAD_W = ucbcs_pkg::MANT_W - ucbcs_pkg::VISITS_W;

  ucbcs_pkg::log_phase_t          phase;
  logic [ucbcs_pkg::MANT_W-1:0]   x;
  logic [EXP_W-1:0]               e;
  logic [ucbcs_pkg::FRAC_BITS-1:0] frac;
  logic [CNT_W-1:0]               cnt;

  logic [2*ucbcs_pkg::MANT_W-1:0] sq;
  logic [ucbcs_pkg::MANT_W:0]     y;

  always_comb begin
    sq = x * x;
    y  = sq[2*ucbcs_pkg::MANT_W-1:ucbcs_pkg::MANT_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ucbcs_pkg::LG_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        ucbcs_pkg::LG_IDLE: begin
          if (start) begin
            x     <= {p, {PAD_W{1'b0}}};
            e     <= EXP_W'(ucbcs_pkg::VISITS_W - 1);
            cnt   <= '0;
            phase <= ucbcs_pkg::LG_NORM;
          end
        end
        ucbcs_pkg::LG_NORM: begin
          if (x[ucbcs_pkg::MANT_W-1]) begin
            phase <= ucbcs_pkg::LG_SQUARE;
          end else begin
            x <= {x[ucbcs_pkg::MANT_W-2:0], 1'b0};
            e <= e - 1'b1;
          end
        end
        ucbcs_pkg::LG_SQUARE: begin
          // square >= 2.0 gives a one bit and a halving
          frac <= {frac[ucbcs_pkg::FRAC_BITS-2:0], y[ucbcs_pkg::MANT_W]};
          x    <= y[ucbcs_pkg::MANT_W] ? y[ucbcs_pkg::MANT_W:1] : y[ucbcs_pkg::MANT_W-1:0];
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(ucbcs_pkg::FRAC_BITS - 1)) begin
            phase <= ucbcs_pkg::LG_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= ucbcs_pkg::LG_IDLE;
      endcase
    end
  end

  assign log_q = {e, frac};

endmodule

>>> design/ucbcs_sqrt.sv
// ----------------------------------------------------------------------------
// ucbcs_sqrt
// Integer square root, one root bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
module ucbcs_sqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ucbcs_pkg::DIVD_W-1:0]    n,
  output logic                            done,
  output logic [ucbcs_pkg::ROOT_W-1:0]    root
);

  localparam int CNT_W = $clog2(ucbcs_pkg::SQRT_STEPS);
  localparam int REM_W = ucbcs_pkg::ROOT_W + 2;

  logic [ucbcs_pkg::DIVD_W-1:0] nsh;
  logic [REM_W-1:0]             rem;
  logic [CNT_W-1:0]             cnt;
  logic                         busy;

  logic [REM_W+1:0]             t;
  logic [REM_W+1:0]             trial;
  logic [REM_W+1:0]             diff;
  logic                         ge;

  always_comb begin
    t     = {rem, nsh[ucbcs_pkg::DIVD_W-1:ucbcs_pkg::DIVD_W-2]};
    trial = {2'b00, root, 2'b01};
    diff  = t - trial;
    ge    = t >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nsh  <= n;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        nsh  <= {nsh[ucbcs_pkg::DIVD_W-3:0], 2'b00};
        rem  <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
        root <= {root[ucbcs_pkg::ROOT_W-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(ucbcs_pkg::SQRT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/ucb1_child_select.sv
// ----------------------------------------------------------------------------
// ucb1_child_select
// UCB1 selection of the best child from a stream of child statistics.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat per child, tdata = {parent_visits, child_wins_half,
//   child_visits}, tlast marks the final child of a node. Master stream: one
//   beat per node, issued after the tlast child, carrying index and score;
//   tuser flags that the first unvisited child was picked.
//   Per child: a visited child runs the win-rate divide, the log normalise
//   and mantissa squares, the ratio divide, the square root and the score
//   and control states in turn before the next child can be accepted, paced
//   by the bit-serial divider, log and root units; a zero parent skips the
//   log. An unvisited or ignored child skips all of these units. tready is
//   high only between children. The result beat is raised from ST_EMIT,
//   after ST_SCORE forms the last child's score and ST_DONE folds it into
//   the running best, or after ST_DONE alone when it is unvisited or ignored.
//   If the receiver stalls, the result waits in the output register and the
//   next node's children are still taken; only the next result then waits.
//   Reset (synchronous) clears the running best, the child count and the output
//   valid flag, and returns explore_weight to 5793 (C = 1.414, Q4.12). The user
//   writes explore_weight via cfg_we/cfg_wdata only while idle; not enforced.
module ucb1_child_select #(
  parameter int MAX_CHILDREN = ucbcs_pkg::MAX_CHILDREN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,    // explore_weight
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,      // child_visits[19:0], child_wins_half[40:20],
                                    // parent_visits[60:41], zero pad
  input  logic        s_tlast,      // last_child
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,      // best_index[5:0], best_score[29:6], zero pad
  output logic        m_tuser       // picked_unvisited
);

  localparam int CNT_W = $clog2(MAX_CHILDREN + 1);
  localparam int VW    = ucbcs_pkg::VISITS_W;
  localparam int WW    = ucbcs_pkg::WINS_W;
  localparam int SW    = ucbcs_pkg::SCORE_W;
  localparam int IW    = ucbcs_pkg::INDEX_W;
  localparam int PRODW = ucbcs_pkg::WEIGHT_W + ucbcs_pkg::ROOT_W;

  ucbcs_pkg::sel_state_t state, state_next;

  // beat fields
  logic [VW-1:0] in_visits, in_parent;
  logic [WW-1:0] in_wins;
  logic          accept;
  logic          in_go;

  assign in_visits = s_tdata[VW-1:0];
  assign in_wins   = s_tdata[VW+WW-1:VW];
  assign in_parent = s_tdata[2*VW+WW-1:VW+WW];
  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == ucbcs_pkg::ST_IDLE);

  // set state
  logic [ucbcs_pkg::WEIGHT_W-1:0] explore_weight;
  logic [SW-1:0]    best_score;
  logic [IW-1:0]    best_index;
  logic [CNT_W-1:0] child_counter;
  logic             unvisited_seen;
  logic             any_seen;

  // per-child working registers
  logic [VW-1:0]    v_reg, p_reg;
  logic             last_reg, go_reg;
  logic [IW-1:0]    idx_reg;
  logic [ucbcs_pkg::EXPL_W-1:0] exploit;
  logic [ucbcs_pkg::LOG_W-1:0]  log_val;
  logic [ucbcs_pkg::LN_W-1:0]   ln_val;
  logic [PRODW-1:0]             explore_prod;
  logic [SW-1:0]                cand_score;

  // unit handshakes
  logic                         div_start, div_done;
  logic [ucbcs_pkg::DIVD_W-1:0] div_dividend, div_quo;
  logic [VW-1:0]                div_divisor;
  logic                         log_start, log_done;
  logic [ucbcs_pkg::LOG_W-1:0]  log_q;
  logic                         sqrt_start, sqrt_done;
  logic [ucbcs_pkg::ROOT_W-1:0] root;

  logic                         out_free;
  logic [ucbcs_pkg::LOG_W+15:0] ln_prod;
  logic [SW:0]                  score_sum;

  assign in_go    = (child_counter < CNT_W'(MAX_CHILDREN)) && !unvisited_seen;
  assign out_free = !m_tvalid || m_tready;
  assign ln_prod  = log_val * ucbcs_pkg::LN2_Q16;
  assign score_sum = (SW+1)'(exploit) +
                     (SW+1)'(explore_prod[PRODW-1:ucbcs_pkg::WEIGHT_W-4]);

  // the win-rate divide starts from the beat itself, the ratio divide from ln
  assign div_dividend = (state == ucbcs_pkg::ST_IDLE) ?
                        {in_wins, 15'd0} : {ln_val, 16'd0};
  assign div_divisor  = (state == ucbcs_pkg::ST_IDLE) ? in_visits : v_reg;

  ucbcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  ucbcs_log2 u_log2 (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .p     (p_reg),
    .done  (log_done),
    .log_q (log_q)
  );

  ucbcs_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .n     (div_quo),
    .done  (sqrt_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ucbcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    log_start  = 1'b0;
    sqrt_start = 1'b0;
    unique case (state)
      ucbcs_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_go && in_visits != '0) begin
            div_start  = 1'b1;
            state_next = ucbcs_pkg::ST_WR;
          end else begin
            state_next = ucbcs_pkg::ST_DONE;
          end
        end
      end
      ucbcs_pkg::ST_WR: begin
        if (div_done) begin
          if (p_reg != '0) begin
            log_start  = 1'b1;
            state_next = ucbcs_pkg::ST_LOG;
          end else begin
            state_next = ucbcs_pkg::ST_LN;
          end
        end
      end
      ucbcs_pkg::ST_LOG: begin
        if (log_done) state_next = ucbcs_pkg::ST_LN;
      end
      ucbcs_pkg::ST_LN:    state_next = ucbcs_pkg::ST_RT_GO;
      ucbcs_pkg::ST_RT_GO: begin
        div_start  = 1'b1;
        state_next = ucbcs_pkg::ST_RT;
      end
      ucbcs_pkg::ST_RT: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_next = ucbcs_pkg::ST_SQRT;
        end
      end
      ucbcs_pkg::ST_SQRT: begin
        if (sqrt_done) state_next = ucbcs_pkg::ST_SCORE;
      end
      ucbcs_pkg::ST_SCORE: state_next = ucbcs_pkg::ST_DONE;
      ucbcs_pkg::ST_DONE:  state_next = ucbcs_pkg::ST_EMIT;
      ucbcs_pkg::ST_EMIT: begin
        if (!last_reg || out_free) state_next = ucbcs_pkg::ST_IDLE;
      end
      default: state_next = ucbcs_pkg::ST_IDLE;
    endcase
  end

  // datapath and set bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      explore_weight <= ucbcs_pkg::WEIGHT_RESET;
      best_score     <= '0;
      best_index     <= '0;
      child_counter  <= '0;
      unvisited_seen <= 1'b0;
      any_seen       <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) explore_weight <= cfg_wdata;
      // new result beat, else drop the one just taken
      if (state == ucbcs_pkg::ST_EMIT && last_reg && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ucbcs_pkg::ST_IDLE: begin
          if (accept) begin
            v_reg    <= in_visits;
            p_reg    <= in_parent;
            last_reg <= s_tlast;
            go_reg   <= in_go;
            idx_reg  <= IW'(child_counter);
            if (child_counter < CNT_W'(MAX_CHILDREN)) child_counter <= child_counter + 1'b1;
          end
        end
        ucbcs_pkg::ST_WR: begin
          if (div_done) begin
            // win rate saturates at 1.0, exploit term then zero
            exploit <= (div_quo >= ucbcs_pkg::DIVD_W'(ucbcs_pkg::WR_ONE)) ? '0 :
                       ucbcs_pkg::WR_ONE - {1'b0, div_quo[ucbcs_pkg::EXPL_W-2:0]};
            log_val <= '0;
          end
        end
        ucbcs_pkg::ST_LOG: begin
          if (log_done) log_val <= log_q;
        end
        ucbcs_pkg::ST_LN: begin
          ln_val <= ln_prod[ucbcs_pkg::LN_W+15:16];
        end
        ucbcs_pkg::ST_SQRT: begin
          if (sqrt_done) explore_prod <= explore_weight * root;
        end
        ucbcs_pkg::ST_SCORE: begin
          cand_score <= score_sum[SW] ? ucbcs_pkg::SCORE_MAX : score_sum[SW-1:0];
        end
        ucbcs_pkg::ST_DONE: begin
          if (go_reg) begin
            any_seen <= 1'b1;
            if (v_reg == '0) begin
              unvisited_seen <= 1'b1;
              best_index     <= idx_reg;
              best_score     <= ucbcs_pkg::SCORE_MAX;
            end else if (!any_seen || cand_score > best_score) begin
              best_index <= idx_reg;
              best_score <= cand_score;
            end
          end
        end
        ucbcs_pkg::ST_EMIT: begin
          if (last_reg && out_free) begin
            m_tdata        <= {{(32-IW-SW){1'b0}}, best_score, best_index};
            m_tuser        <= unvisited_seen;
            best_score     <= '0;
            best_index     <= '0;
            child_counter  <= '0;
            unvisited_seen <= 1'b0;
            any_seen       <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> design/ucbcs_checker.sv
// ----------------------------------------------------------------------------
// ucbcs_checker
// Port-level checks for ucb1_child_select, bound to the top level.
// ----------------------------------------------------------------------------
module ucbcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // a held result beat stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  // reset leaves the block ready and with no result
  a_reset: assert property (@(posedge clk) rst |=> s_tready && !m_tvalid)
    else $error("block not idle after reset");

  // a child beat always occupies the block for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready during child processing");

  // an unvisited pick carries the saturated score
  a_unvisited: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[29:6] == 24'hFFFFFF)
    else $error("unvisited pick without saturated score");

endmodule

bind ucb1_child_select ucbcs_checker u_ucbcs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives child statistics into the UCB1 selector and checks every result
// beat against an in-bench fixed-point score model.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXC = ucbcs_pkg::MAX_CHILDREN_DEF;
  localparam longint LIMIT = 2_000_000;

  typedef struct packed {
    logic [ucbcs_pkg::INDEX_W-1:0] index;
    logic [ucbcs_pkg::SCORE_W-1:0] score;
    logic                          unvisited;
  } pick_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;

  ucb1_child_select dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // model state
  logic [15:0]                   weight;
  logic [ucbcs_pkg::SCORE_W-1:0] best_score;
  logic [ucbcs_pkg::INDEX_W-1:0] best_index;
  int unsigned        n_children;
  bit                 seen_unvisited, seen_any;
  pick_t              picks_due[$];
  int                 errors = 0;
  longint             cycles = 0;
  bit                 hold_off = 1'b0;  // long receiver stall requested

  function automatic logic [20:0] log2_q16(logic [19:0] p);
    int unsigned e;
    logic [63:0] x;
    logic [15:0] frac;
    e = 0;
    frac = '0;
    while (e < 31 && (p >> (e + 1)) != 0) e++;
    x = 64'(p) << (30 - e);
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd1 << 31)) begin
        frac[0] = 1'b1;
        x = x >> 1;
      end
    end
    return {5'(e), frac};
  endfunction

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] res, b;
    res = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [ucbcs_pkg::SCORE_W-1:0] ucb_score(logic [19:0] v,
                                                              logic [20:0] w,
                                                              logic [19:0] p);
    logic [63:0] wr, ln, sc;
    wr = (64'(w) << 15) / v;
    if (wr > 65536) wr = 65536;
    ln = (p != 0) ? ((64'(log2_q16(p)) * 45426) >> 16) : 64'd0;
    sc = (65536 - wr) + ((64'(weight) * root64((ln << 16) / v)) >> 12);
    if (sc > 64'hFFFFFF) sc = 64'hFFFFFF;
    return sc[ucbcs_pkg::SCORE_W-1:0];
  endfunction

  function automatic void clear_node();
    best_score = '0;
    best_index = '0;
    n_children = 0;
    seen_unvisited = 0;
    seen_any = 0;
  endfunction

  // fold one accepted child into the running choice
  function automatic void take_child(logic [19:0] v, logic [20:0] w, logic [19:0] p,
                                     logic last);
    logic [ucbcs_pkg::SCORE_W-1:0] s;
    pick_t pk;
    if (n_children < MAXC) begin
      if (!seen_unvisited) begin
        if (v == 0) begin
          seen_unvisited = 1;
          best_index = ucbcs_pkg::INDEX_W'(n_children);
          best_score = ucbcs_pkg::SCORE_MAX;
        end else begin
          s = ucb_score(v, w, p);
          if (!seen_any || s > best_score) begin
            best_score = s;
            best_index = ucbcs_pkg::INDEX_W'(n_children);
          end
        end
        seen_any = 1;
      end
      n_children++;
    end
    if (last) begin
      pk = '{best_index, best_score, seen_unvisited};
      picks_due = {picks_due, pk};
      clear_node();
    end
  endfunction

  // sender gap: mostly short, now and then long
  task automatic gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                    : ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
    repeat (n) @(posedge clk);
  endtask

  task automatic send_child(logic [19:0] v, logic [20:0] w, logic [19:0] p, logic last);
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b0, p, w, v};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    take_child(v, w, p, last);
    s_tvalid <= 1'b0;
    // block is busy after a beat anyway
    @(posedge clk);
  endtask

  // wait for all results, then let the block finish any ignored tail
  task automatic drain();
    while (picks_due.size() != 0 && cycles < LIMIT) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_weight(logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    weight = val;
  endtask

  task automatic random_child(output logic [19:0] v, output logic [20:0] w,
                              output logic [19:0] p);
    case ($urandom_range(0, 7))
      0: v = 20'($urandom);
      1: v = 20'($urandom_range(0, 3));
      default: v = 20'($urandom_range(1, 2000));
    endcase
    if ($urandom_range(0, 29) == 0) v = 0;
    w = ($urandom_range(0, 5) == 0) ? 21'($urandom) : 21'($urandom_range(0, 2 * v));
    p = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 5000));
  endtask

  task automatic random_node(int count, logic [19:0] p_fixed, bit fix_p);
    logic [19:0] v, p;
    logic [20:0] w;
    for (int i = 0; i < count; i++) begin
      random_child(v, w, p);
      if (fix_p) p = p_fixed;
      send_child(v, w, p, i == count - 1);
      gap();
    end
  endtask

  task automatic test_directed();
    send_child(20'hFFFFF, 21'h1FFFFF, 20'hFFFFF, 1'b1);   // extremes, wins above visits
    send_child(20'd1, 21'd0, 20'hFFFFF, 1'b1);            // largest explore term
    send_child(20'd5, 21'd3, 20'd0, 1'b0);                // parent unvisited
    send_child(20'd5, 21'd3, 20'd0, 1'b1);                // tie keeps first
    send_child(20'd10, 21'd4, 20'd100, 1'b0);
    send_child(20'd0, 21'h1FFFFF, 20'd100, 1'b0);         // first unvisited
    send_child(20'd0, 21'd0, 20'd100, 1'b0);              // later ones ignored
    send_child(20'd1, 21'd0, 20'd100, 1'b1);
    send_child(20'd0, 21'd0, 20'd0, 1'b1);
    send_child(20'd3, 21'd7, 20'd1, 1'b0);
    send_child(20'd2, 21'd1, 20'd2, 1'b1);
  endtask

  task automatic test_too_many();
    logic [19:0] v, p;
    logic [20:0] w;
    for (int i = 0; i < MAXC + 6; i++) begin
      random_child(v, w, p);
      if (v == 0) v = 1;
      if (i == MAXC + 2) v = 0;                           // beyond the cap: ignored
      send_child(v, w, p, i == MAXC + 5);
    end
  endtask

  task automatic test_weights();
    set_weight(16'd0);
    random_node(4, 20'd777, 1);
    set_weight(16'hFFFF);
    send_child(20'd1, 21'd0, 20'hFFFFF, 1'b1);            // explore term at the largest weight
    random_node(4, 20'd777, 1);
    set_weight(16'h5A5A);
    random_node(5, 20'd300, 1);
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 300) begin
      automatic int n = $urandom_range(1, 6);
      random_node(n, 20'($urandom_range(0, 100000)), $urandom_range(0, 3) != 0);
      sent += n;
      if ($urandom_range(0, 15) == 0) set_weight(16'($urandom));
    end
  endtask

  // result fills the output register, next node's work then stalls the input
  task automatic test_backpressure();
    drain();
    hold_off = 1'b1;
    random_node(3, 20'd50, 1);
    random_node(3, 20'd50, 1);
    random_node(2, 20'd50, 1);
    hold_off = 1'b0;
  endtask

  // receiver: random stalls, long ones on request
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
      n = $urandom_range(0, 9);
      m_tready <= (n >= 3);
      if (n == 0) begin
        repeat ($urandom_range(10, 80)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    pick_t exp_pick;
    if (!rst && m_tvalid && m_tready) begin
      if (picks_due.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        exp_pick = picks_due.pop_front();
        if (m_tdata[5:0] !== exp_pick.index) begin
          $error("best_index exp %0d got %0d", exp_pick.index, m_tdata[5:0]);
          errors++;
        end
        if (m_tdata[29:6] !== exp_pick.score) begin
          $error("best_score exp %0h got %0h", exp_pick.score, m_tdata[29:6]);
          errors++;
        end
        if (m_tuser !== exp_pick.unvisited) begin
          $error("picked_unvisited exp %0b got %0b", exp_pick.unvisited, m_tuser);
          errors++;
        end
      end
    end
  end

  // run-time watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    weight = ucbcs_pkg::WEIGHT_RESET;
    clear_node();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_too_many();
    test_backpressure();
    test_weights();
    test_random();
    set_weight(ucbcs_pkg::WEIGHT_RESET);
    random_node(3, 20'd99, 1);
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
